// ===== rtl/core/plr_pkg.sv =====
// shared constants and codes for the positional linked list core
// no dependencies; compile first
package plr_pkg;

   // fixed payload widths
   localparam int ACTION_W   = 2;
   localparam int POSITION_W = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int LENGTH_W   = 7;

   // default node store size
   localparam int CAPACITY_DEF = 64;

   // request actions (code 3 is undefined and fails)
   typedef enum logic [ACTION_W-1:0] {
      ACT_GET    = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2
   } action_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ===== rtl/core/plr_if.sv =====
// valid/ready channel interfaces for the request and response beats
// depends on plr_pkg
interface plr_req_if;
   import plr_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [ACTION_W-1:0]          action;
   logic [POSITION_W-1:0]        position;
   logic signed [VALUE_W-1:0]    item_value;

   modport source (output valid, action, position, item_value, input ready);
   modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface plr_rsp_if;
   import plr_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic signed [VALUE_W-1:0]    read_value;
   logic [LENGTH_W-1:0]          length;

   modport source (output valid, status, read_value, length, input ready);
   modport sink   (input valid, status, read_value, length, output ready);
endinterface

// ===== rtl/core/positional_linked_list_core.sv =====
// positional linked list core: top level, sequencer and node store
// depends on plr_pkg, plr_if (plr_req_if, plr_rsp_if) and plr_ram
//
// Holds an ordered list of up to CAPACITY signed 32-bit values in two node
// memories (values and next links) with a free list of unused nodes. Each
// request beat gets, inserts before, or deletes the element at a one-based
// position and returns one response beat with status, the element read or
// removed, and the resulting length. One request is handled at a time: the
// walk from the head follows one link per cycle through the link memory's
// read port. A finished response sits in an output register, so the next
// request is taken while it waits. Link memory entries never allocated
// since reset read as their reset chain through a fill count, so no
// clearing pass is needed after reset.
module positional_linked_list_core #(
   parameter int CAPACITY = plr_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   plr_req_if.sink    req_chan,
   plr_rsp_if.source  rsp_chan
);
   import plr_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W  = ((IDX_W > POSITION_W) ? IDX_W : POSITION_W) + 1;
   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK,
      S_GET_VAL,
      S_INS_POP,
      S_INS_LINK,
      S_INS_SPLICE,
      S_INS_HOOK,
      S_DEL_NEXT,
      S_DEL_RDQ,
      S_DEL_UNLINK,
      S_DEL_FREE,
      S_DONE
   } state_type;

   state_type                state_ff;
   logic [ACTION_W-1:0]      act_ff;
   logic                     pos_one_ff;
   logic [VALUE_W-1:0]       val_ff;
   logic [POSITION_W-1:0]    steps_ff;
   logic [IDX_W-1:0]         node_ff;
   logic                     pend_ff;
   logic [IDX_W-1:0]         new_ff;
   logic [IDX_W-1:0]         del_ff;
   logic [IDX_W-1:0]         head_ff;
   logic [IDX_W-1:0]         free_ff;
   logic [IDX_W-1:0]         fill_ff;
   logic [IDX_W-1:0]         count_ff;
   logic [STATUS_W-1:0]      res_status_ff;
   logic [VALUE_W-1:0]       res_value_ff;
   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [VALUE_W-1:0]       rsp_value_ff;
   logic [LENGTH_W-1:0]      rsp_length_ff;

   // memory ports
   logic                     link_wr_en;
   logic [ADDR_W-1:0]        link_wr_addr;
   logic [IDX_W-1:0]         link_wr_data;
   logic                     link_rd_en;
   logic [ADDR_W-1:0]        link_rd_addr;
   logic [IDX_W-1:0]         link_rd;
   logic                     value_wr_en;
   logic [ADDR_W-1:0]        value_wr_addr;
   logic                     value_rd_en;
   logic [ADDR_W-1:0]        value_rd_addr;
   logic [VALUE_W-1:0]       value_rd;

   logic                     req_beat;
   logic                     rsp_beat;
   logic [CMP_W-1:0]         pos_x;
   logic [CMP_W-1:0]         cnt_x;
   logic                     pos_ok_read;
   logic                     pos_ok_ins;
   logic                     store_full;
   logic [IDX_W-1:0]         cur_idx;
   logic                     fresh;
   logic [IDX_W-1:0]         free_next;

   plr_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd)
   );

   plr_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (value_wr_en),
      .wr_addr (value_wr_addr),
      .wr_data (val_ff),
      .rd_en   (value_rd_en),
      .rd_addr (value_rd_addr),
      .rd_data (value_rd)
   );

   // handshakes
   assign req_chan.ready      = (state_ff == S_IDLE);
   assign req_beat            = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_beat            = rsp_valid_ff && rsp_chan.ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.length     = rsp_length_ff;

   // range and capacity checks on the incoming beat
   assign pos_x       = CMP_W'(req_chan.position);
   assign cnt_x       = CMP_W'(count_ff);
   assign pos_ok_read = (req_chan.position != '0) && (pos_x <= cnt_x);
   assign pos_ok_ins  = (req_chan.position != '0) && (pos_x <= cnt_x + CMP_W'(1));
   assign store_full  = (count_ff >= NULL_IDX) || (free_ff == NULL_IDX);

   // current walk node: link just read, or the start node
   assign cur_idx = pend_ff ? link_rd : node_ff;

   // never-allocated nodes are treated as the reset chain i -> i+1
   assign fresh     = (free_ff >= fill_ff);
   assign free_next = fresh ? (free_ff + IDX_W'(1)) : link_rd;

   // memory access decode per state
   always_comb begin
      link_wr_en    = 1'b0;
      link_wr_addr  = free_ff[ADDR_W-1:0];
      link_wr_data  = head_ff;
      link_rd_en    = 1'b0;
      link_rd_addr  = cur_idx[ADDR_W-1:0];
      value_wr_en   = 1'b0;
      value_wr_addr = free_ff[ADDR_W-1:0];
      value_rd_en   = 1'b0;
      value_rd_addr = cur_idx[ADDR_W-1:0];
      unique case (state_ff)
         S_WALK: begin
            if (steps_ff != '0) begin
               link_rd_en = 1'b1;
            end else if (act_ff == ACT_GET) begin
               value_rd_en = 1'b1;
            end else if (act_ff == ACT_DELETE) begin
               link_rd_en = 1'b1;
            end
         end
         S_INS_POP: begin
            link_rd_en   = 1'b1;
            link_rd_addr = free_ff[ADDR_W-1:0];
         end
         S_INS_LINK: begin
            value_wr_en = 1'b1;
            if (pos_one_ff) begin
               link_wr_en = 1'b1;
            end else begin
               link_rd_en   = 1'b1;
               link_rd_addr = node_ff[ADDR_W-1:0];
            end
         end
         S_INS_SPLICE: begin
            link_wr_en   = 1'b1;
            link_wr_addr = new_ff[ADDR_W-1:0];
            link_wr_data = link_rd;
         end
         S_INS_HOOK: begin
            link_wr_en   = 1'b1;
            link_wr_addr = node_ff[ADDR_W-1:0];
            link_wr_data = new_ff;
         end
         S_DEL_NEXT: begin
            link_rd_en    = 1'b1;
            link_rd_addr  = link_rd[ADDR_W-1:0];
            value_rd_en   = 1'b1;
            value_rd_addr = link_rd[ADDR_W-1:0];
         end
         S_DEL_RDQ: begin
            link_rd_en    = 1'b1;
            link_rd_addr  = del_ff[ADDR_W-1:0];
            value_rd_en   = 1'b1;
            value_rd_addr = del_ff[ADDR_W-1:0];
         end
         S_DEL_UNLINK: begin
            if (!pos_one_ff) begin
               link_wr_en   = 1'b1;
               link_wr_addr = node_ff[ADDR_W-1:0];
               link_wr_data = link_rd;
            end
         end
         S_DEL_FREE: begin
            link_wr_en   = 1'b1;
            link_wr_addr = del_ff[ADDR_W-1:0];
            link_wr_data = free_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer, list registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         head_ff      <= NULL_IDX;
         free_ff      <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_beat) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  act_ff        <= req_chan.action;
                  pos_one_ff    <= (req_chan.position == POSITION_W'(1));
                  val_ff        <= req_chan.item_value;
                  node_ff       <= head_ff;
                  del_ff        <= head_ff;
                  pend_ff       <= 1'b0;
                  res_status_ff <= ST_RANGE;
                  res_value_ff  <= '0;
                  state_ff      <= S_DONE;
                  case (req_chan.action)
                     ACT_GET: begin
                        steps_ff <= req_chan.position - POSITION_W'(1);
                        if (pos_ok_read) begin
                           state_ff <= S_WALK;
                        end
                     end
                     ACT_INSERT: begin
                        steps_ff <= req_chan.position - POSITION_W'(2);
                        if (pos_ok_ins && store_full) begin
                           res_status_ff <= ST_FULL;
                        end else if (pos_ok_ins) begin
                           state_ff <= (req_chan.position == POSITION_W'(1)) ?
                                       S_INS_POP : S_WALK;
                        end
                     end
                     ACT_DELETE: begin
                        steps_ff <= req_chan.position - POSITION_W'(2);
                        if (pos_ok_read) begin
                           state_ff <= (req_chan.position == POSITION_W'(1)) ?
                                       S_DEL_RDQ : S_WALK;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            // one link per cycle from the head
            S_WALK: begin
               node_ff <= cur_idx;
               if (steps_ff != '0) begin
                  pend_ff  <= 1'b1;
                  steps_ff <= steps_ff - POSITION_W'(1);
               end else begin
                  pend_ff <= 1'b0;
                  case (act_ff)
                     ACT_GET:    state_ff <= S_GET_VAL;
                     ACT_INSERT: state_ff <= S_INS_POP;
                     default:    state_ff <= S_DEL_NEXT;
                  endcase
               end
            end
            S_GET_VAL: begin
               res_status_ff <= ST_OK;
               res_value_ff  <= value_rd;
               state_ff      <= S_DONE;
            end
            S_INS_POP: begin
               state_ff <= S_INS_LINK;
            end
            // take the free head, store the value
            S_INS_LINK: begin
               new_ff  <= free_ff;
               free_ff <= free_next;
               if (fresh) begin
                  fill_ff <= free_ff + IDX_W'(1);
               end
               if (pos_one_ff) begin
                  head_ff       <= free_ff;
                  count_ff      <= count_ff + IDX_W'(1);
                  res_status_ff <= ST_OK;
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_INS_SPLICE;
               end
            end
            S_INS_SPLICE: begin
               state_ff <= S_INS_HOOK;
            end
            S_INS_HOOK: begin
               count_ff      <= count_ff + IDX_W'(1);
               res_status_ff <= ST_OK;
               state_ff      <= S_DONE;
            end
            S_DEL_NEXT: begin
               del_ff   <= link_rd;
               state_ff <= S_DEL_UNLINK;
            end
            S_DEL_RDQ: begin
               state_ff <= S_DEL_UNLINK;
            end
            // bypass the removed node
            S_DEL_UNLINK: begin
               res_value_ff <= value_rd;
               if (pos_one_ff) begin
                  head_ff <= link_rd;
               end
               state_ff <= S_DEL_FREE;
            end
            // removed node goes to the front of the free list
            S_DEL_FREE: begin
               free_ff       <= del_ff;
               count_ff      <= count_ff - IDX_W'(1);
               res_status_ff <= ST_OK;
               state_ff      <= S_DONE;
            end
            // load the response register once it is free
            S_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_value_ff  <= res_value_ff;
                  rsp_length_ff <= LENGTH_W'(count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/plr_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read data
// no dependencies
module plr_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
